FILE: rtl/core/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared constants and field widths of the MIDI polyphony statistics block.
// ----------------------------------------------------------------------------
package mps_pkg;

  // Sizes of the note store
  localparam int unsigned CHANNELS   = 16;
  localparam int unsigned NOTES      = 128;
  localparam int unsigned MAX_REPEAT = 15;

  localparam int unsigned SLOTS    = CHANNELS * NOTES;
  localparam int unsigned ADDR_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(MAX_REPEAT + 1);
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths of the ports
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned ACT_W   = 11;
  localparam int unsigned TOT_W   = 15;
  localparam int unsigned DRUM_W  = 8;
  localparam int unsigned REM_W   = 4;

  // Reset value of the drum channel register
  localparam logic [CHAN_W-1:0] DRUM_CHANNEL_RST = 4'd9;

  // Event codes
  localparam logic FUNC_NOTE_ON  = 1'b0;
  localparam logic FUNC_NOTE_OFF = 1'b1;

endpackage

FILE: rtl/core/midi_polyphony_stats.sv
// ----------------------------------------------------------------------------
// midi_polyphony_stats
// Polyphony statistics over MIDI note-on / note-off events.
// ----------------------------------------------------------------------------
// After reset the block sweeps its copy-count RAM and its drum map RAM to
// zero, one entry per cycle (CHANNELS*NOTES = 2048 entries), and holds
// in_ready_o low meanwhile; drum channel writes are taken at any time.
// Afterwards the accept edge of each item reads the copy count
// of its (channel, note) slot and the drum map entry of its note, and
// ST_EXEC then updates both, writes them back and loads the result register.
// A result waiting in the output register does not block the next accept; it
// only holds the update cycle of the following item.
// ----------------------------------------------------------------------------
module midi_polyphony_stats (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // drum channel register
  input  logic                        cfg_we_i,
  input  logic [mps_pkg::CHAN_W-1:0]  cfg_wdata_i,
  // event input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [mps_pkg::CHAN_W-1:0]  channel_i,
  input  logic [mps_pkg::NOTE_W-1:0]  note_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mps_pkg::ACT_W-1:0]   channel_active_o,
  output logic [mps_pkg::ACT_W-1:0]   channel_peak_o,
  output logic [mps_pkg::TOT_W-1:0]   total_active_o,
  output logic [mps_pkg::TOT_W-1:0]   total_peak_o,
  output logic [mps_pkg::DRUM_W-1:0]  drum_kinds_o,
  output logic [mps_pkg::REM_W-1:0]   removed_copies_o,
  output logic                        saturated_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // Control state
  logic [1:0]                     state_q, state_d;
  logic [mps_pkg::ADDR_W-1:0]     clr_addr_q, clr_addr_d;
  logic [mps_pkg::CHAN_W-1:0]     drum_channel_q;

  // Held event
  logic                           func_q;
  logic [mps_pkg::CHAN_W-1:0]     chan_q;
  logic [mps_pkg::NOTE_W-1:0]     note_q;
  logic [mps_pkg::ADDR_W-1:0]     slot_q;

  // Statistics
  logic [mps_pkg::ACT_W-1:0]      chan_active_q [mps_pkg::CHANNELS];
  logic [mps_pkg::ACT_W-1:0]      chan_peak_q   [mps_pkg::CHANNELS];
  logic [mps_pkg::TOT_W-1:0]      sum_active_q, sum_active_d;
  logic [mps_pkg::TOT_W-1:0]      sum_peak_q, sum_peak_d;
  logic [mps_pkg::DRUM_W-1:0]     drum_total_q, drum_total_d;

  // Result register
  logic                           out_valid_q, out_valid_d;
  logic [mps_pkg::ACT_W-1:0]      res_ca_q, res_cp_q;
  logic [mps_pkg::TOT_W-1:0]      res_ta_q, res_tp_q;
  logic [mps_pkg::DRUM_W-1:0]     res_drum_q;
  logic [mps_pkg::REM_W-1:0]      res_rem_q;
  logic                           res_sat_q;

  // RAM port signals
  logic                           ram_we;
  logic [mps_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr, in_slot;
  logic [mps_pkg::CNT_W-1:0]      ram_wdata, cnt_rd;
  logic                           drum_we, drum_wdata, drum_seen_rd;
  logic [mps_pkg::NOTE_W-1:0]     drum_waddr, drum_raddr;

  // Update datapath
  logic                           accept, go, ch_ok, is_off, sat, inc, drum_hit;
  logic [mps_pkg::CH_IDX_W-1:0]   ch_idx;
  logic [mps_pkg::CNT_W-1:0]      removed, cnt_new;
  logic [mps_pkg::ACT_W-1:0]      ca_cur, cp_cur, ca_new, cp_new;

  assign accept  = in_valid_i && in_ready_o;
  assign in_slot = mps_pkg::ADDR_W'({channel_i, note_i});

  // Copy-count store
  mps_ram #(
    .WIDTH (mps_pkg::CNT_W),
    .DEPTH (mps_pkg::SLOTS)
  ) u_copy_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (cnt_rd)
  );

  // Drum note map
  mps_ram #(
    .WIDTH (1),
    .DEPTH (mps_pkg::NOTES)
  ) u_drum_ram (
    .clk_i   (clk_i),
    .we_i    (drum_we),
    .waddr_i (drum_waddr),
    .wdata_i (drum_wdata),
    .raddr_i (drum_raddr),
    .rdata_o (drum_seen_rd)
  );

  // Read the new slot on accept, else reread the held slot during a stall
  assign ram_raddr  = accept ? in_slot : slot_q;
  assign drum_raddr = accept ? note_i : note_q;

  // Decode the held event against the read copy count
  always_comb begin
    ch_idx   = chan_q[mps_pkg::CH_IDX_W-1:0];
    ch_ok    = ({1'b0, chan_q} < (mps_pkg::CHAN_W + 1)'(mps_pkg::CHANNELS));
    is_off   = (func_q == mps_pkg::FUNC_NOTE_OFF);
    go       = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
    sat      = ch_ok && !is_off && (cnt_rd >= mps_pkg::CNT_W'(mps_pkg::MAX_REPEAT));
    inc      = ch_ok && !is_off && !sat;
    removed  = (ch_ok && is_off) ? cnt_rd : '0;
    cnt_new  = is_off ? '0 : (cnt_rd + 1'b1);
    drum_hit = ch_ok && !is_off && (chan_q == drum_channel_q) && !drum_seen_rd;

    ca_cur = chan_active_q[ch_idx];
    cp_cur = chan_peak_q[ch_idx];
    if (is_off) begin
      ca_new = ca_cur - mps_pkg::ACT_W'(removed);
    end else if (inc) begin
      ca_new = ca_cur + 1'b1;
    end else begin
      ca_new = ca_cur;
    end
    cp_new = (inc && (ca_new > cp_cur)) ? ca_new : cp_cur;

    if (ch_ok && is_off) begin
      sum_active_d = sum_active_q - mps_pkg::TOT_W'(removed);
    end else if (inc) begin
      sum_active_d = sum_active_q + 1'b1;
    end else begin
      sum_active_d = sum_active_q;
    end
    sum_peak_d   = (inc && (sum_active_d > sum_peak_q)) ? sum_active_d : sum_peak_q;
    drum_total_d = drum_hit ? (drum_total_q + 1'b1) : drum_total_q;
  end

  // Write ports: clearing sweep, else write back the updated entries
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we     = 1'b1;
      ram_waddr  = clr_addr_q;
      ram_wdata  = '0;
      drum_we    = 1'b1;
      drum_waddr = clr_addr_q[mps_pkg::NOTE_W-1:0];
      drum_wdata = 1'b0;
    end else begin
      ram_we     = go && ch_ok && (is_off || !sat);
      ram_waddr  = slot_q;
      ram_wdata  = cnt_new;
      drum_we    = go && drum_hit;
      drum_waddr = note_q;
      drum_wdata = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == mps_pkg::ADDR_W'(mps_pkg::SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = go || (out_valid_q && !out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_addr_q     <= '0;
      out_valid_q    <= 1'b0;
      drum_channel_q <= mps_pkg::DRUM_CHANNEL_RST;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        drum_channel_q <= cfg_wdata_i;
      end
    end
  end

  // Statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mps_pkg::CHANNELS); i++) begin
        chan_active_q[i] <= '0;
        chan_peak_q[i]   <= '0;
      end
      sum_active_q <= '0;
      sum_peak_q   <= '0;
      drum_total_q <= '0;
    end else if (go) begin
      if (ch_ok) begin
        chan_active_q[ch_idx] <= ca_new;
        chan_peak_q[ch_idx]   <= cp_new;
      end
      sum_active_q <= sum_active_d;
      sum_peak_q   <= sum_peak_d;
      drum_total_q <= drum_total_d;
    end
  end

  // Hold the accepted event and load the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      chan_q <= channel_i;
      note_q <= note_i;
      slot_q <= in_slot;
    end
    if (go) begin
      res_ca_q   <= ch_ok ? ca_new : '0;
      res_cp_q   <= ch_ok ? cp_new : '0;
      res_ta_q   <= sum_active_d;
      res_tp_q   <= sum_peak_d;
      res_drum_q <= drum_total_d;
      res_rem_q  <= mps_pkg::REM_W'(removed);
      res_sat_q  <= sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_active_o = res_ca_q;
  assign channel_peak_o   = res_cp_q;
  assign total_active_o   = res_ta_q;
  assign total_peak_o     = res_tp_q;
  assign drum_kinds_o     = res_drum_q;
  assign removed_copies_o = res_rem_q;
  assign saturated_o      = res_sat_q;

  // Checks
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted item did not enter the update cycle");

  a_no_ram_write_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("copy-count RAM written while idle");

  a_chan_within_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({4'b0, channel_active_o} <= total_active_o))
    else $error("channel held count exceeds total held count");

  a_peak_covers_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (channel_peak_o >= channel_active_o))
    else $error("channel peak below channel held count");

  a_sat_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (removed_copies_o == '0))
    else $error("saturated note on reports removed copies");

endmodule

FILE: rtl/core/mps_ram.sv
// ----------------------------------------------------------------------------
// mps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
